FILE: rtl/core/clws_pkg.sv
// ----------------------------------------------------------------------------
// clws_pkg
// Shared types and constants for the character LCD write sequencer.
// ----------------------------------------------------------------------------
package clws_pkg;

   localparam int MAX_DIGITS  = 10;
   localparam int BIN_W       = 32;
   localparam int BCD_W       = 4 * MAX_DIGITS;
   localparam int CNT_W       = 5;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CSR_ADDR_W  = 3;

   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] CH_SPACE    = 8'd32;
   localparam logic [7:0] FUNC_8BIT   = 8'b00111000;
   localparam logic [7:0] DISPLAY_ON  = 8'b00001100;
   localparam logic [7:0] CLEAR_DISP  = 8'h01;
   localparam logic [3:0] FUNC_NIB_HI = 4'b0010;
   localparam logic [3:0] FUNC_NIB_LO = 4'b1000;

   localparam logic [0:0] REG_BUS_MODE = 1'b0;

   typedef enum logic [2:0] {
      CMD_RAW_CMD  = 3'd0,
      CMD_RAW_DATA = 3'd1,
      CMD_INIT     = 3'd2,
      CMD_GOTO     = 3'd3,
      CMD_NUMBER   = 3'd4,
      CMD_BLANK    = 3'd5
   } cmd_type;

   typedef enum logic [3:0] {
      F_IDLE,
      F_BYTE,
      F_INIT,
      F_GOTO,
      F_BLANK,
      F_SIGN,
      F_CONV,
      F_SKIP,
      F_DIGIT
   } front_state_type;

   // one queued bus write: split means two strobes on a four-bit bus
   typedef struct packed {
      logic       rs;
      logic [7:0] value;
      logic       split;
      logic       wait_mark;
      logic       last;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

endpackage

FILE: rtl/core/char_lcd_write_sequencer_top.sv
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer_top
// Expands character-display requests into enable-strobe writes for an
// HD44780-style LCD bus.
// ----------------------------------------------------------------------------
// The request side takes a new transaction whenever its decoder is idle. After
// the accepting cycle, raw bytes, initialise, cursor move and blank cells
// occupy it while their byte writes are queued. Print number occupies it for
// a minus sign when negative, a binary-to-decimal conversion loop, a
// leading-zero scan and then one queued write per digit. A full queue stalls
// the decoder. A four-entry queue separates the decoder from the strobe
// generator, which delivers one strobe per cycle when the result side is
// ready, two per byte on a four-bit bus. The user must write bus mode through
// the register port only while the block is idle; the block itself does not
// enforce this. There is no clearing pass.
// ----------------------------------------------------------------------------
module char_lcd_write_sequencer_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // byte_value[7:0], number[39:8], column[45:40], row[47:46], cell_count[52:48]
   input  logic [55:0]                     req_tdata,
   // command[2:0]
   input  logic [2:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // bus_value[7:0], power_on_wait[8]
   output logic [15:0]                     rsp_tdata,
   // reg_select[0]
   output logic                            rsp_tuser,
   output logic                            rsp_tlast,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [clws_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import clws_pkg::*;

   logic      bus_mode_ff, bus_mode_in;
   logic      csr_wr;
   push_type  push;
   entry_type head;
   logic      queue_full;
   logic      queue_empty;
   logic      pop;
   logic [7:0] bus_value;
   logic      power_on_wait;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_BUS_MODE) ? {31'd0, bus_mode_ff} : 32'd0;

   always_comb begin
      bus_mode_in = bus_mode_ff;
      if (csr_wr && csr_paddr[2] == REG_BUS_MODE) begin
         bus_mode_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_mode_ff <= 1'b1;
      end else begin
         bus_mode_ff <= bus_mode_in;
      end
   end

   clws_front u_front (
      .clock      (clock),
      .reset      (reset),
      .bus_mode   (bus_mode_ff),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .command    (cmd_type'(req_tuser)),
      .byte_value (req_tdata[7:0]),
      .number     (req_tdata[39:8]),
      .column     (req_tdata[45:40]),
      .row        (req_tdata[47:46]),
      .cell_count (req_tdata[52:48]),
      .queue_full (queue_full),
      .push       (push)
   );

   clws_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .pop   (pop),
      .empty (queue_empty),
      .head  (head)
   );

   clws_back u_back (
      .clock         (clock),
      .reset         (reset),
      .bus_mode      (bus_mode_ff),
      .empty         (queue_empty),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .reg_select    (rsp_tuser),
      .bus_value     (bus_value),
      .power_on_wait (power_on_wait),
      .last          (rsp_tlast)
   );

   assign rsp_tdata = {7'd0, power_on_wait, bus_value};

endmodule

FILE: rtl/core/clws_front.sv
// ----------------------------------------------------------------------------
// clws_front
// Request decoder: expands one request into queued byte writes.
// ----------------------------------------------------------------------------
module clws_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              bus_mode,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  clws_pkg::cmd_type                 command,
   input  logic [7:0]                        byte_value,
   input  logic signed [clws_pkg::BIN_W-1:0] number,
   input  logic [5:0]                        column,
   input  logic [1:0]                        row,
   input  logic [4:0]                        cell_count,
   input  logic                              queue_full,
   output clws_pkg::push_type                push
);
   import clws_pkg::*;

   localparam logic [2:0] STEP_FUNC0 = 3'd0;
   localparam logic [2:0] STEP_FUNC1 = 3'd1;
   localparam logic [2:0] STEP_FUNC2 = 3'd2;
   localparam logic [2:0] STEP_DISP  = 3'd3;
   localparam logic [2:0] STEP_CLEAR = 3'd4;
   localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(BIN_W - 1);

   front_state_type   state_ff, state_in;
   logic [2:0]        step_ff, step_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rs_ff, rs_in;
   logic [7:0]        byte_ff, byte_in;
   logic [7:0]        addr_ff, addr_in;
   logic              blank_ff, blank_in;
   logic [BCD_W-1:0]  bcd_ff, bcd_in;
   logic [BIN_W-1:0]  bin_ff, bin_in;
   logic [BIN_W-1:0]  mag;
   logic [BCD_W-1:0]  bcd_adj;
   logic [3:0]        top_digit;
   logic              push_ok;

   assign mag       = number[BIN_W-1] ? (BIN_W'(0) - BIN_W'(number)) : BIN_W'(number);
   assign top_digit = bcd_ff[BCD_W-1 -: 4];
   assign push_ok   = push.valid && !queue_full;

   always_comb begin
      for (int d = 0; d < MAX_DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end else begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4];
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               priority case (command)
                  CMD_RAW_CMD, CMD_RAW_DATA: state_in = F_BYTE;
                  CMD_INIT:                  state_in = F_INIT;
                  CMD_GOTO, CMD_BLANK:       state_in = F_GOTO;
                  CMD_NUMBER: begin
                     if (number == '0) begin
                        state_in = F_BYTE;
                     end else if (number[BIN_W-1]) begin
                        state_in = F_SIGN;
                     end else begin
                        state_in = F_CONV;
                     end
                  end
                  default:                   state_in = F_IDLE;
               endcase
            end
         end
         F_BYTE:  if (push_ok) state_in = F_IDLE;
         F_INIT:  if (push_ok && step_ff == STEP_CLEAR) state_in = F_IDLE;
         F_GOTO: begin
            if (push_ok) begin
               state_in = (blank_ff && cnt_ff != '0) ? F_BLANK : F_IDLE;
            end
         end
         F_BLANK: if (push_ok && cnt_ff == CNT_W'(1)) state_in = F_IDLE;
         F_SIGN:  if (push_ok) state_in = F_CONV;
         F_CONV:  if (cnt_ff == CONV_LAST) state_in = F_SKIP;
         F_SKIP:  if (top_digit != 4'd0) state_in = F_DIGIT;
         F_DIGIT: if (push_ok && cnt_ff == CNT_W'(1)) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready             = (state_ff == F_IDLE);
      push.valid            = 1'b0;
      push.entry.rs         = 1'b0;
      push.entry.value      = '0;
      push.entry.split      = 1'b1;
      push.entry.wait_mark  = 1'b0;
      push.entry.last       = 1'b0;
      unique case (state_ff)
         F_BYTE: begin
            push.valid       = 1'b1;
            push.entry.rs    = rs_ff;
            push.entry.value = byte_ff;
            push.entry.last  = 1'b1;
         end
         F_INIT: begin
            unique case (step_ff)
               STEP_FUNC0: begin
                  push.valid           = 1'b1;
                  push.entry.split     = 1'b0;
                  push.entry.wait_mark = 1'b1;
                  push.entry.value     = bus_mode ? {4'd0, FUNC_NIB_HI} : FUNC_8BIT;
               end
               STEP_FUNC1: begin
                  push.valid       = 1'b1;
                  push.entry.split = 1'b0;
                  push.entry.value = {4'd0, FUNC_NIB_HI};
               end
               STEP_FUNC2: begin
                  push.valid       = 1'b1;
                  push.entry.split = 1'b0;
                  push.entry.value = {4'd0, FUNC_NIB_LO};
               end
               STEP_DISP: begin
                  push.valid       = 1'b1;
                  push.entry.value = DISPLAY_ON;
               end
               STEP_CLEAR: begin
                  push.valid       = 1'b1;
                  push.entry.value = CLEAR_DISP;
                  push.entry.last  = 1'b1;
               end
               default: push.valid = 1'b0;
            endcase
         end
         F_GOTO: begin
            push.valid       = 1'b1;
            push.entry.value = addr_ff;
            push.entry.last  = !blank_ff || (cnt_ff == '0);
         end
         F_BLANK: begin
            push.valid       = 1'b1;
            push.entry.rs    = 1'b1;
            push.entry.value = CH_SPACE;
            push.entry.last  = (cnt_ff == CNT_W'(1));
         end
         F_SIGN: begin
            push.valid       = 1'b1;
            push.entry.rs    = 1'b1;
            push.entry.value = CH_MINUS;
         end
         F_DIGIT: begin
            push.valid       = 1'b1;
            push.entry.rs    = 1'b1;
            push.entry.value = CH_ZERO | {4'd0, top_digit};
            push.entry.last  = (cnt_ff == CNT_W'(1));
         end
         default: push.valid = 1'b0;
      endcase
   end

   // datapath
   always_comb begin
      step_in  = step_ff;
      cnt_in   = cnt_ff;
      rs_in    = rs_ff;
      byte_in  = byte_ff;
      addr_in  = addr_ff;
      blank_in = blank_ff;
      bcd_in   = bcd_ff;
      bin_in   = bin_ff;
      unique case (state_ff)
         F_IDLE: begin
            step_in  = STEP_FUNC0;
            cnt_in   = (command == CMD_NUMBER) ? '0 : cell_count;
            rs_in    = (command == CMD_RAW_DATA) || (command == CMD_NUMBER);
            byte_in  = (command == CMD_NUMBER) ? CH_ZERO : byte_value;
            addr_in  = {1'b1, row[0], column};
            blank_in = (command == CMD_BLANK);
            bcd_in   = '0;
            bin_in   = mag;
         end
         F_INIT: begin
            if (push_ok) begin
               step_in = (step_ff == STEP_FUNC0 && !bus_mode) ? STEP_DISP : step_ff + 3'd1;
            end
         end
         F_BLANK, F_DIGIT: begin
            if (push_ok) begin
               cnt_in = cnt_ff - CNT_W'(1);
               bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
            end
         end
         F_CONV: begin
            {bcd_in, bin_in} = {bcd_adj, bin_ff} << 1;
            cnt_in = (cnt_ff == CONV_LAST) ? CNT_W'(MAX_DIGITS) : cnt_ff + CNT_W'(1);
         end
         F_SKIP: begin
            if (top_digit == 4'd0) begin
               bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         default: begin
            step_in = step_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      cnt_ff   <= cnt_in;
      rs_ff    <= rs_in;
      byte_ff  <= byte_in;
      addr_ff  <= addr_in;
      blank_ff <= blank_in;
      bcd_ff   <= bcd_in;
      bin_ff   <= bin_in;
   end

endmodule

FILE: rtl/core/clws_queue.sv
// ----------------------------------------------------------------------------
// clws_queue
// Short queue of byte writes between the decoder and the strobe generator.
// ----------------------------------------------------------------------------
module clws_queue (
   input  logic                clock,
   input  logic                reset,
   input  clws_pkg::push_type  push,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output clws_pkg::entry_type head
);
   import clws_pkg::*;

   entry_type              mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full    = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push.valid && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_PTR_W+1)'(do_push) - (QUEUE_PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

FILE: rtl/core/clws_back.sv
// ----------------------------------------------------------------------------
// clws_back
// Strobe generator: turns queued byte writes into bus strobes, high nibble
// first on a four-bit bus, behind an output register.
// ----------------------------------------------------------------------------
module clws_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                bus_mode,
   input  logic                empty,
   input  clws_pkg::entry_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                reg_select,
   output logic [7:0]          bus_value,
   output logic                power_on_wait,
   output logic                last
);
   import clws_pkg::*;

   logic       valid_ff, valid_in;
   logic       pend_ff, pend_in;
   logic [3:0] pend_nib_ff, pend_nib_in;
   logic       pend_last_ff, pend_last_in;
   logic       rs_ff, rs_in;
   logic [7:0] val_ff, val_in;
   logic       wait_ff, wait_in;
   logic       last_ff, last_in;
   logic       load;

   assign load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in     = valid_ff;
      pend_in      = pend_ff;
      pend_nib_in  = pend_nib_ff;
      pend_last_in = pend_last_ff;
      rs_in        = rs_ff;
      val_in       = val_ff;
      wait_in      = wait_ff;
      last_in      = last_ff;
      pop          = 1'b0;
      if (load) begin
         if (pend_ff) begin
            valid_in = 1'b1;
            pend_in  = 1'b0;
            val_in   = {4'd0, pend_nib_ff};
            wait_in  = 1'b0;
            last_in  = pend_last_ff;
         end else if (!empty) begin
            pop      = 1'b1;
            valid_in = 1'b1;
            rs_in    = head.rs;
            wait_in  = head.wait_mark;
            if (head.split && bus_mode) begin
               val_in       = {4'd0, head.value[7:4]};
               last_in      = 1'b0;
               pend_in      = 1'b1;
               pend_nib_in  = head.value[3:0];
               pend_last_in = head.last;
            end else begin
               val_in  = head.value;
               last_in = head.last;
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_nib_ff  <= pend_nib_in;
      pend_last_ff <= pend_last_in;
      rs_ff        <= rs_in;
      val_ff       <= val_in;
      wait_ff      <= wait_in;
      last_ff      <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign reg_select    = rs_ff;
   assign bus_value     = val_ff;
   assign power_on_wait = wait_ff;
   assign last          = last_ff;

endmodule

FILE: rtl/core/clws_checker.sv
// ----------------------------------------------------------------------------
// clws_checker
// Port-level checks on the result channel and register port.
// ----------------------------------------------------------------------------
module clws_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast,
   input logic        csr_pready
);

   // stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // nothing pending right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // power-on wait only on an instruction strobe that is not the last
   a_wait_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |-> !rsp_tuser && !rsp_tlast)
      else $error("power-on wait on wrong strobe");

   // register port never inserts wait states
   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("pready low");

endmodule

bind char_lcd_write_sequencer_top clws_checker u_clws_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast),
   .csr_pready (csr_pready)
);

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the character LCD write sequencer. Display requests go in on the
// request stream and are expanded locally into the expected enable strobes
// (register select, bus value, power-on wait mark, last). The strobes on the
// result stream are compared in order. Both streams see random stalls. Bus
// mode is rewritten and read back over the register port between phases.
// ----------------------------------------------------------------------------
module testbench;
   import clws_pkg::*;

   localparam int LIMIT_CYCLES  = 2000000;
   localparam int SETTLE_CYCLES = 100;
   localparam int RANDOM_PHASES = 4;
   localparam int PHASE_ITEMS   = 40;

   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;
   localparam logic       MODE_8BIT   = 1'b0;
   localparam logic       MODE_4BIT   = 1'b1;
   localparam logic       RS_INSTR    = 1'b0;
   localparam logic       RS_DATA     = 1'b1;
   localparam logic [7:0] GOTO_FLAG   = 8'h80;
   localparam logic [CSR_ADDR_W-1:0] BUS_MODE_ADDR = CSR_ADDR_W'(4 * REG_BUS_MODE);

   typedef struct packed {
      logic [2:0]  command;
      logic [4:0]  cell_count;
      logic [1:0]  row;
      logic [5:0]  column;
      logic [31:0] number;
      logic [7:0]  byte_value;
   } lcd_request_type;

   typedef struct packed {
      logic       reg_select;
      logic [7:0] bus_value;
      logic       power_on_wait;
      logic       last;
   } lcd_strobe_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   lcd_request_type req_item = '0;
   lcd_request_type pending_q[$];
   lcd_strobe_type  strobe_q[$];
   logic         bus_mode_shadow = MODE_4BIT;
   int           requests_queued = 0;
   int           requests_taken = 0;
   int           errors = 0;
   int           cycle_count = 0;
   int           req_gap = 0;
   int           rsp_gap = 0;
   int           req_calm = 0;
   int           rsp_calm = 0;
   bit           req_took = 1'b0;
   bit           rsp_took = 1'b0;

   // byte_value, number, column, row, cell_count from bit 0 up
   assign req_tdata = {3'b000, req_item.cell_count, req_item.row, req_item.column,
                       req_item.number, req_item.byte_value};
   // command
   assign req_tuser = req_item.command;

   char_lcd_write_sequencer_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch %s: got %0h expected %0h", $time, field, got, want);
      errors++;
   endtask

   // mostly short gaps, a few long ones, and now and then a stall-free stretch
   task automatic pick_gap(inout int calm, output int gap);
      int r;
      r = $urandom_range(0, 99);
      gap = 0;
      if (calm > 0)
         calm--;
      else if (r < 3)
         calm = $urandom_range(10, 40);
      else if (r < 50)
         gap = 0;
      else if (r < 88)
         gap = $urandom_range(1, 3);
      else
         gap = $urandom_range(8, 40);
   endtask

   task automatic push_strobe(input logic rs, input logic [7:0] value, input logic mark);
      strobe_q.push_back('{reg_select: rs, bus_value: value, power_on_wait: mark,
                           last: 1'b0});
   endtask

   task automatic push_byte(input logic rs, input logic [7:0] value);
      if (bus_mode_shadow == MODE_4BIT) begin
         push_strobe(rs, {4'h0, value[7:4]}, 1'b0);
         push_strobe(rs, {4'h0, value[3:0]}, 1'b0);
      end else begin
         push_strobe(rs, value, 1'b0);
      end
   endtask

   task automatic push_cursor(input logic [1:0] row, input logic [5:0] column);
      logic [7:0] addr;
      addr = {row, 6'b0} + {2'b00, column};
      push_byte(RS_INSTR, addr | GOTO_FLAG);
   endtask

   task automatic push_decimal(input logic [31:0] number);
      logic [31:0] mag;
      logic [3:0]  digit[MAX_DIGITS];
      int          nd;
      int          k;
      mag = number;
      nd = 0;
      if (number == 0) begin
         push_byte(RS_DATA, CH_ZERO);
      end else begin
         if (number[31]) begin
            push_byte(RS_DATA, CH_MINUS);
            mag = 32'd0 - number;
         end
         while (mag != 0 && nd < MAX_DIGITS) begin
            digit[nd] = 4'(mag % 10);
            mag = mag / 10;
            nd++;
         end
         for (k = nd - 1; k >= 0; k--)
            push_byte(RS_DATA, CH_ZERO + {4'h0, digit[k]});
      end
   endtask

   // expected strobes of one accepted request, last flag on the final one
   task automatic expand_request(input lcd_request_type r);
      int             first;
      int             k;
      lcd_strobe_type tail;
      first = strobe_q.size();
      case (r.command)
         CMD_RAW_CMD:  push_byte(RS_INSTR, r.byte_value);
         CMD_RAW_DATA: push_byte(RS_DATA, r.byte_value);
         CMD_INIT: begin
            if (bus_mode_shadow == MODE_4BIT) begin
               push_strobe(RS_INSTR, {4'h0, FUNC_NIB_HI}, 1'b1);
               push_strobe(RS_INSTR, {4'h0, FUNC_NIB_HI}, 1'b0);
               push_strobe(RS_INSTR, {4'h0, FUNC_NIB_LO}, 1'b0);
            end else begin
               push_strobe(RS_INSTR, FUNC_8BIT, 1'b1);
            end
            push_byte(RS_INSTR, DISPLAY_ON);
            push_byte(RS_INSTR, CLEAR_DISP);
         end
         CMD_GOTO:     push_cursor(r.row, r.column);
         CMD_NUMBER:   push_decimal(r.number);
         CMD_BLANK: begin
            push_cursor(r.row, r.column);
            for (k = 0; k < r.cell_count; k++)
               push_byte(RS_DATA, CH_SPACE);
         end
         default: ;
      endcase
      if (strobe_q.size() > first) begin
         tail = strobe_q.pop_back();
         tail.last = 1'b1;
         strobe_q.push_back(tail);
      end
   endtask

   task automatic queue_request(input logic [2:0] command, input logic [7:0] byte_value,
                                input logic [31:0] number, input logic [5:0] column,
                                input logic [1:0] row, input logic [4:0] cell_count);
      pending_q.push_back('{command: command, cell_count: cell_count, row: row,
                            column: column, number: number, byte_value: byte_value});
      requests_queued++;
   endtask

   task automatic queue_random_request();
      lcd_request_type r;
      r.command    = 3'($urandom_range(int'(CMD_RAW_CMD), int'(CMD_BLANK)));
      r.byte_value = 8'($urandom);
      r.number     = $urandom;
      r.column     = 6'($urandom_range(0, 63));
      r.row        = 2'($urandom_range(0, 3));
      r.cell_count = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                                 : 5'($urandom_range(0, 6));
      if (r.command == CMD_NUMBER) begin
         case ($urandom_range(0, 3))
            0: r.number = $urandom_range(0, 999);
            1: r.number = 32'd0 - 32'($urandom_range(1, 99999));
            2: begin
               case ($urandom_range(0, 3))
                  0: r.number = 32'h8000_0000;
                  1: r.number = 32'h7FFF_FFFF;
                  2: r.number = 32'hFFFF_FFFF;
                  default: r.number = 32'd0;
               endcase
            end
            default: ;
         endcase
      end
      queue_request(r.command, r.byte_value, r.number, r.column, r.row, r.cell_count);
   endtask

   task automatic wait_idle();
      while (requests_taken != requests_queued || strobe_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_bus_mode(input logic mode);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= BUS_MODE_ADDR;
      csr_pwdata  <= {31'b0, mode};
      @(negedge clock) csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      bus_mode_shadow = mode;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock) csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {31'b0, mode})
         report_mismatch("bus_mode readback", csr_prdata, {31'b0, mode});
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // request driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_took) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               req_item   <= pending_q.pop_front();
               req_tvalid <= 1'b1;
               pick_gap(req_calm, req_gap);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_took)
            pick_gap(rsp_calm, rsp_gap);
         else if (rsp_gap == 0 && $urandom_range(0, 15) == 0)
            rsp_gap = $urandom_range(1, 3);
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      lcd_strobe_type want;
      req_took = !reset && req_tvalid && req_tready;
      rsp_took = !reset && rsp_tvalid && rsp_tready;
      if (req_took) begin
         expand_request(req_item);
         requests_taken++;
      end
      if (rsp_took) begin
         if (strobe_q.size() == 0) begin
            report_mismatch("unexpected strobe", {15'b0, rsp_tuser, rsp_tdata}, '0);
         end else begin
            want = strobe_q.pop_front();
            if (rsp_tuser !== want.reg_select)
               report_mismatch("reg_select", 32'(rsp_tuser), 32'(want.reg_select));
            if (rsp_tdata[7:0] !== want.bus_value)
               report_mismatch("bus_value", 32'(rsp_tdata[7:0]), 32'(want.bus_value));
            if (rsp_tdata[8] !== want.power_on_wait)
               report_mismatch("power_on_wait", 32'(rsp_tdata[8]),
                               32'(want.power_on_wait));
            if (rsp_tlast !== want.last)
               report_mismatch("last", 32'(rsp_tlast), 32'(want.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int p;
      int k;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // four-bit bus straight out of reset
      queue_request(CMD_RAW_CMD, 8'h00, '0, '0, '0, '0);
      queue_request(CMD_RAW_DATA, 8'hFF, '1, '1, '1, '1);
      queue_request(CMD_INIT, '0, '0, '0, '0, '0);
      queue_request(CMD_GOTO, '0, '0, 6'd0, 2'd0, '0);
      queue_request(CMD_GOTO, '0, '0, 6'd63, 2'd3, '0);
      queue_request(CMD_NUMBER, '0, 32'd0, '0, '0, '0);
      queue_request(CMD_NUMBER, '0, 32'h8000_0000, '0, '0, '0);
      queue_request(CMD_NUMBER, '0, 32'h7FFF_FFFF, '0, '0, '0);
      queue_request(CMD_NUMBER, '0, 32'hFFFF_FFFF, '0, '0, '0);
      queue_request(CMD_NUMBER, '0, 32'd7, '0, '0, '0);
      queue_request(CMD_BLANK, '0, '0, 6'd5, 2'd1, 5'd0);
      queue_request(CMD_BLANK, '0, '0, 6'd63, 2'd3, 5'd31);
      queue_request(CMD_SPARE_6, 8'hFF, '1, '1, '1, '1);
      queue_request(CMD_SPARE_7, '0, '0, '0, '0, '0);
      wait_idle();

      // eight-bit bus
      set_bus_mode(MODE_8BIT);
      queue_request(CMD_RAW_CMD, 8'hA5, '0, '0, '0, '0);
      queue_request(CMD_RAW_DATA, 8'h5A, '0, '0, '0, '0);
      queue_request(CMD_INIT, '0, '0, '0, '0, '0);
      queue_request(CMD_NUMBER, '0, 32'hFFFF_FFF6, '0, '0, '0);
      queue_request(CMD_BLANK, '0, '0, 6'd40, 2'd2, 5'd1);
      queue_request(CMD_GOTO, '0, '0, 6'd17, 2'd2, '0);

      for (p = 0; p < RANDOM_PHASES; p++) begin
         wait_idle();
         set_bus_mode((p % 2 == 0) ? MODE_4BIT : MODE_8BIT);
         for (k = 0; k < PHASE_ITEMS; k++)
            queue_random_request();
      end

      wait_idle();
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/clws_pkg.sv
rtl/core/clws_front.sv
rtl/core/clws_queue.sv
rtl/core/clws_back.sv
rtl/core/char_lcd_write_sequencer_top.sv
rtl/core/clws_checker.sv
tb/sv/testbench.sv
